// ===== hw/rtl/mil_pkg.sv =====
package mil_pkg;

  // Parser phase, one-hot. Any code outside these is handled as the header phase.
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_VALUE  = 3'b010,
    PH_SKIP   = 3'b100
  } mil_phase_t;

  // Positions within the item header.
  localparam logic [1:0] HDR_TYPE   = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;

  // One input transaction: a payload byte and its framing flags.
  typedef struct packed {
    logic        start_flag;
    logic [15:0] item_count;
    logic [7:0]  data_byte;
    logic        end_flag;
  } mil_item_t;

  // One output transaction.
  typedef struct packed {
    logic       keep_byte;
    logic [7:0] out_byte;
    logic       record_done;
    logic [9:0] record_len;
    logic       list_done;
  } mil_result_t;

  // Parser state carried from byte to byte.
  typedef struct packed {
    mil_phase_t  phase;
    logic [1:0]  header_index;
    logic [15:0] item_length;
    logic [15:0] kept_length;
    logic [15:0] byte_offset;
    logic [15:0] items_parsed;
    logic [15:0] items_expected;
  } mil_state_t;

  localparam mil_state_t MIL_STATE_RESET = '{
    phase:          PH_HEADER,
    header_index:   2'd0,
    item_length:    16'd0,
    kept_length:    16'd0,
    byte_offset:    16'd0,
    items_parsed:   16'd0,
    items_expected: 16'd0
  };

endpackage

// ===== hw/rtl/mil_core.sv =====
module mil_core
  import mil_pkg::*;
#(
  parameter int MAX_RECORD = 512
) (
  input  mil_state_t  state,
  input  mil_item_t   item,
  output mil_state_t  state_next,
  output mil_result_t result
);

  // Longest value part kept in a record; the type byte makes up the rest.
  localparam logic [16:0] KEEP_MAX = 17'(MAX_RECORD - 1);

  mil_state_t  cur;
  mil_state_t  nxt;
  logic        finish;
  logic [16:0] off_inc;
  logic [15:0] new_len;
  logic [15:0] new_kept;
  logic [15:0] parsed_inc;
  logic [16:0] len_plus;

  assign off_inc    = {1'b0, state.byte_offset} + 17'd1;
  assign new_len    = {state.item_length[15:8], item.data_byte};
  assign new_kept   = ({1'b0, new_len} < KEEP_MAX) ? new_len : KEEP_MAX[15:0];
  assign len_plus   = {1'b0, cur.kept_length} + 17'd1;

  // Per-byte update of the parser.
  always_comb begin
    cur = state;
    // A start byte clears the parser and loads the announced count first.
    if (item.start_flag) begin
      cur = MIL_STATE_RESET;
      cur.items_expected = item.item_count;
    end

    nxt    = cur;
    finish = 1'b0;
    result = '0;

    unique case (cur.phase)
      PH_VALUE: begin
        result.keep_byte = 1'b1;
        result.out_byte  = item.data_byte;
        nxt.byte_offset  = off_inc[15:0];
        if (off_inc >= {1'b0, cur.kept_length}) begin
          if (cur.kept_length < cur.item_length) begin
            nxt.phase = PH_SKIP;
          end else begin
            finish             = 1'b1;
            result.record_done = 1'b1;
            result.record_len  = len_plus[9:0];
          end
        end
      end
      PH_SKIP: begin
        nxt.byte_offset = off_inc[15:0];
        if (off_inc >= {1'b0, cur.item_length}) begin
          finish             = 1'b1;
          result.record_done = 1'b1;
          result.record_len  = len_plus[9:0];
        end
      end
      default: begin
        unique case (cur.header_index)
          HDR_TYPE: begin
            result.keep_byte = 1'b1;
            result.out_byte  = item.data_byte;
            nxt.header_index = HDR_LEN_HI;
          end
          HDR_LEN_HI: begin
            nxt.item_length  = {item.data_byte, 8'h00};
            nxt.header_index = HDR_LEN_LO;
          end
          default: begin
            nxt.item_length  = new_len;
            nxt.kept_length  = new_kept;
            nxt.byte_offset  = 16'd0;
            nxt.header_index = HDR_TYPE;
            // A zero-length item closes on its last header byte.
            if (new_len == 16'd0) begin
              finish             = 1'b1;
              result.record_done = 1'b1;
              result.record_len  = 10'd1;
            end else begin
              nxt.phase = PH_VALUE;
            end
          end
        endcase
      end
    endcase

    // Close the item and check the list count.
    parsed_inc = cur.items_parsed + 16'd1;
    if (finish) begin
      nxt.phase        = PH_HEADER;
      nxt.header_index = HDR_TYPE;
      nxt.byte_offset  = 16'd0;
      nxt.items_parsed = parsed_inc;
      if (parsed_inc == cur.items_expected) begin
        result.list_done = 1'b1;
        nxt.item_length  = 16'd0;
        nxt.kept_length  = 16'd0;
        nxt.items_parsed = 16'd0;
      end
    end

    // An end byte clears the parser after it has been used, keeping the announced item count.
    if (item.end_flag) begin
      nxt                = MIL_STATE_RESET;
      nxt.items_expected = cur.items_expected;
    end

    state_next = nxt;
  end

endmodule

// ===== hw/rtl/media_item_list_parser.sv =====
// Folder-items response parser, one payload byte per transaction.
// Input channel item_valid / item_stall / item carries a byte with its start
// and end flags; the start byte also carries the announced item count.
// Output channel result_valid / result_stall / result gives one transaction
// per input byte: the record byte with its keep flag, the record end with its
// length, and the list end.
// Each byte passes an input register, one step of parser logic, and the
// result register. Throughput is one byte per cycle while result_stall is
// low, set by the combinational parser update.
// When the receiver stalls, the result holds and a byte is still taken into
// the input register while it is empty; once it is full, item_stall rises
// until the result drains.
// A synchronous reset empties both registers and returns the parser to the
// header phase with a zero item count.
module media_item_list_parser
  import mil_pkg::*;
#(
  parameter int MAX_RECORD = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  mil_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output mil_result_t result
);

  logic        held_valid;
  mil_item_t   held;
  mil_state_t  state;
  mil_state_t  state_next;
  mil_result_t step_result;
  logic        take;
  logic        advance;

  // Handshake: the input register moves on whenever the result register frees.
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  mil_core #(
    .MAX_RECORD(MAX_RECORD)
  ) u_core (
    .state     (state),
    .item      (held),
    .state_next(state_next),
    .result    (step_result)
  );

  // Control and parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= MIL_STATE_RESET;
    end else begin
      if (take) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      held <= item;
    end
    if (advance) begin
      result <= step_result;
    end
  end

endmodule

// ===== hw/rtl/mil_checker.sv =====
module mil_checker
  import mil_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input mil_result_t result
);

  // A stalled result transaction stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The list can only finish on the byte that closes a record.
  a_list_on_record: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.list_done |-> result.record_done)
    else $error("list_done without record_done");

  // Dropped bytes and open records carry zero fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.keep_byte || result.out_byte == 8'd0) &&
                     (result.record_done || result.record_len == 10'd0))
    else $error("unused result field not zero");

  // A byte accepted while no result is shown leads to a valid result through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid |=> ##1 result_valid)
    else $error("accepted byte produced no result");

  // Nothing is shown straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind media_item_list_parser mil_checker u_mil_checker (.*);
